FILE: rtl/core/vbgls_pkg.sv
// shared types and constants for the burst/gap loss statistics block
package vbgls_pkg;

	// event codes on the input command field
	localparam logic [1:0] CMD_RECV = 2'd0;
	localparam logic [1:0] CMD_LOST = 2'd1;
	localparam logic [1:0] CMD_DISC = 2'd2;

	// ratio slots, in output order
	localparam logic [1:0] RAT_LOSS    = 2'd0;
	localparam logic [1:0] RAT_DISCARD = 2'd1;
	localparam logic [1:0] RAT_BURST   = 2'd2;
	localparam logic [1:0] RAT_GAP     = 2'd3;

	localparam int IN_W        = 8;
	localparam int FRAC_BITS   = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [7:0] GMIN_RESET = 8'd16;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_RECV = 2'd1,
		OP_LOST = 2'd2,
		OP_DISC = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] reps;
	} op_t;

	// first member lands in the high bits
	typedef struct packed {
		logic [7:0] gap_ratio;
		logic [7:0] burst_ratio;
		logic [7:0] discard_ratio;
		logic [7:0] loss_ratio;
	} res_t;

	typedef struct packed {
		logic start;
		logic round_up;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/core/vbgls_front.sv
// front stage: accepts input items and classifies them into operations
module vbgls_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [1:0]                 s_tuser,   // command[1:0]
	input  logic [vbgls_pkg::IN_W-1:0] s_tdata,   // repeat_count[7:0]
	output logic                       op_valid,
	input  logic                       op_ready,
	output vbgls_pkg::op_t             op_data
);
	import vbgls_pkg::*;

	logic       valid_s1;
	op_t        op_s1;
	op_t        op_c;
	logic [1:0] cmd;
	logic [7:0] reps;

	assign cmd  = s_tuser;
	assign reps = s_tdata;

	always_comb begin
		op_c.reps = reps;
		case (cmd)
			CMD_RECV: op_c.kind = OP_RECV;
			CMD_LOST: op_c.kind = (reps == 8'd0) ? OP_NONE : OP_LOST;
			CMD_DISC: op_c.kind = OP_DISC;
			default:  op_c.kind = OP_NONE;
		endcase
	end

	assign s_tready = !valid_s1 || op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= op_c;
		end
	end

	assign op_valid = valid_s1;
	assign op_data  = op_s1;

endmodule

FILE: rtl/core/vbgls_queue.sv
// short operation queue between the front and back parts
module vbgls_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vbgls_pkg::op_t in_op,
	output logic           out_valid,
	input  logic           out_ready,
	output vbgls_pkg::op_t out_op
);
	import vbgls_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [NW-1:0] FULL = NW'(QUEUE_DEPTH);

	op_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q != FULL);
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_op;
		end
	end

endmodule

FILE: rtl/core/vbgls_div.sv
// iterative ratio divider: 256*num/den, one quotient bit per cycle, saturated
module vbgls_div #(
	parameter int DW = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vbgls_pkg::div_req_t req,
	input  logic [DW-1:0]       num,
	input  logic [DW-1:0]       den,
	output vbgls_pkg::div_stat_t stat,
	output logic [7:0]          quo
);
	import vbgls_pkg::*;

	localparam int QW = FRAC_BITS + 1;
	localparam int SW = $clog2(FRAC_BITS);
	localparam logic [SW-1:0] LAST_STEP = SW'(FRAC_BITS - 1);

	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_RUN  = 3'b010,
		DV_FIN  = 3'b100
	} div_state_t;

	div_state_t    st_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] q_q;
	logic          round_q;
	logic [DW:0]   rem2;
	logic [DW:0]   diff;
	logic          ge;
	logic [QW-1:0] sum;

	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = (rem2 >= {1'b0, den_q});

	// round up when requested and a remainder is left
	assign sum = q_q + QW'(round_q && (rem_q != '0));
	assign quo = sum[QW-1] ? 8'hFF : sum[7:0];

	assign stat.busy = (st_q != DV_IDLE);
	assign stat.done = (st_q == DV_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DV_IDLE;
		end else begin
			case (st_q)
				DV_IDLE: begin
					if (req.start) begin
						st_q <= (den == '0 || num >= den) ? DV_FIN : DV_RUN;
					end
				end
				DV_RUN: begin
					if (step_q == LAST_STEP) begin
						st_q <= DV_FIN;
					end
				end
				DV_FIN:  st_q <= DV_IDLE;
				default: st_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: begin
				if (req.start) begin
					den_q   <= den;
					round_q <= req.round_up;
					step_q  <= '0;
					if (den == '0) begin
						q_q   <= '0;
						rem_q <= '0;
					end else if (num >= den) begin
						// quotient at least 256, saturates
						q_q   <= {1'b1, {(QW-1){1'b0}}};
						rem_q <= '0;
					end else begin
						q_q   <= '0;
						rem_q <= num;
					end
				end
			end
			DV_RUN: begin
				step_q <= step_q + SW'(1);
				q_q    <= {q_q[QW-2:0], ge};
				rem_q  <= ge ? diff[DW-1:0] : rem2[DW-1:0];
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/vbgls_back.sv
// back part: counter update, burst/gap classification and ratio sequencing
module vbgls_back #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            gap_threshold,
	input  logic                  op_valid,
	output logic                  op_ready,
	input  vbgls_pkg::op_t        op_data,
	output vbgls_pkg::div_req_t   div_req,
	output logic [COUNTER_WIDTH+1:0] div_num,
	output logic [COUNTER_WIDTH+1:0] div_den,
	input  vbgls_pkg::div_stat_t  div_stat,
	input  logic [7:0]            div_quo,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output vbgls_pkg::res_t       m_res
);
	import vbgls_pkg::*;

	localparam int CW = COUNTER_WIDTH;
	localparam int DW = COUNTER_WIDTH + 2;
	localparam logic [CW-1:0] ONE = CW'(1);

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_LOSS  = 5'b00010,
		B_CALC  = 5'b00100,
		B_WAIT  = 5'b01000,
		B_WRITE = 5'b10000
	} back_state_t;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? {CW{1'b1}} : s[CW-1:0];
	endfunction

	back_state_t   state_q;
	logic [7:0]    left_q;
	logic          is_lost_q;
	logic [1:0]    ridx_q;
	res_t          res_q;
	res_t          out_q;
	logic          out_valid_q;
	logic          out_free;

	logic [CW-1:0] rt_q, lt_q, dt_q, rsl_q, run_q, rig_q, lig_q, rib_q, lib_q;
	logic [CW-1:0] rt_d, lt_d, dt_d, rsl_d, run_d, rig_d, lig_d, rib_d, lib_d;
	logic          loss_gap;

	assign op_ready = (state_q == B_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_res    = out_q;

	assign loss_gap = (rsl_q >= CW'(gap_threshold)) || (rt_q <= CW'(gap_threshold));

	// counter next values
	always_comb begin
		rt_d  = rt_q;
		lt_d  = lt_q;
		dt_d  = dt_q;
		rsl_d = rsl_q;
		run_d = run_q;
		rig_d = rig_q;
		lig_d = lig_q;
		rib_d = rib_q;
		lib_d = lib_q;
		case (state_q)
			B_IDLE: begin
				if (op_valid) begin
					case (op_data.kind)
						OP_RECV: begin
							rt_d  = sat_add(rt_q, ONE);
							rsl_d = sat_add(rsl_q, ONE);
						end
						OP_DISC: dt_d = sat_add(dt_q, ONE);
						default: ;
					endcase
				end
			end
			B_LOSS: begin
				if (is_lost_q) begin
					lt_d = sat_add(lt_q, ONE);
				end
				if (loss_gap) begin
					if (run_q == ONE) begin
						lig_d = sat_add(lig_q, ONE);
					end else begin
						lib_d = sat_add(lib_q, ONE);
					end
					run_d = ONE;
					rig_d = sat_add(rig_q, rsl_q);
				end else begin
					run_d = sat_add(run_q, ONE);
					rib_d = sat_add(rib_q, rsl_q);
					lib_d = sat_add(lib_q, ONE);
				end
				rsl_d = '0;
			end
			default: ;
		endcase
	end

	// operands of the ratio in progress
	always_comb begin
		div_req.start    = (state_q == B_CALC);
		div_req.round_up = (ridx_q == RAT_BURST) || (ridx_q == RAT_GAP);
		case (ridx_q)
			RAT_LOSS: begin
				div_num = DW'(lt_q);
				div_den = DW'(rt_q) + DW'(lt_q) + DW'(dt_q);
			end
			RAT_DISCARD: begin
				div_num = DW'(dt_q);
				div_den = DW'(rt_q) + DW'(lt_q) + DW'(dt_q);
			end
			RAT_BURST: begin
				div_num = DW'(lib_q);
				div_den = DW'(rib_q) + DW'(lib_q);
			end
			default: begin
				div_num = DW'(lig_q);
				div_den = DW'(rig_q) + DW'(lig_q) + DW'(rsl_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			rt_q        <= '0;
			lt_q        <= '0;
			dt_q        <= '0;
			rsl_q       <= '0;
			run_q       <= ONE;
			rig_q       <= '0;
			lig_q       <= '0;
			rib_q       <= '0;
			lib_q       <= '0;
		end else begin
			rt_q  <= rt_d;
			lt_q  <= lt_d;
			dt_q  <= dt_d;
			rsl_q <= rsl_d;
			run_q <= run_d;
			rig_q <= rig_d;
			lig_q <= lig_d;
			rib_q <= rib_d;
			lib_q <= lib_d;
			// a new result fills the empty register or replaces the one just taken
			if (state_q == B_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (op_valid) begin
						case (op_data.kind)
							OP_LOST: state_q <= B_LOSS;
							OP_DISC: state_q <= B_LOSS;
							default: state_q <= B_CALC;
						endcase
					end
				end
				B_LOSS: begin
					if (left_q == 8'd1) begin
						state_q <= B_CALC;
					end
				end
				B_CALC: state_q <= B_WAIT;
				B_WAIT: begin
					if (div_stat.done) begin
						state_q <= (ridx_q == RAT_GAP) ? B_WRITE : B_CALC;
					end
				end
				B_WRITE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ridx_q    <= RAT_LOSS;
				is_lost_q <= (op_data.kind == OP_LOST);
				left_q    <= (op_data.kind == OP_LOST) ? op_data.reps : 8'd1;
			end
			B_LOSS: left_q <= left_q - 8'd1;
			B_WAIT: begin
				if (div_stat.done) begin
					ridx_q <= ridx_q + 2'd1;
					case (ridx_q)
						RAT_LOSS:    res_q.loss_ratio    <= div_quo;
						RAT_DISCARD: res_q.discard_ratio <= div_quo;
						RAT_BURST:   res_q.burst_ratio   <= div_quo;
						default:     res_q.gap_ratio     <= div_quo;
					endcase
				end
			end
			B_WRITE: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/voip_burst_gap_loss_stats.sv
// top level of the voip burst/gap packet loss statistics block
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  s_      | s_tvalid / s_tready  | s_tuser[1:0] command, s_tdata[7:0] repeat_count
//  m_      | m_tvalid / m_tready  | m_tdata loss, discard, burst, gap ratios (8b each)
//  cfg_    | cfg_valid / cfg_ready| cfg_data gap threshold (Gmin)
//
// an item is taken, then worked once per lost packet (repeat_count for a
// loss event, one for a discard), then four ratios go through the shared
// divider, each with a setup, a step per quotient bit and a finish, and
// last the output register is loaded; a ratio with a zero denominator or
// a quotient of 256 or more skips the quotient bit steps
// an item passes the front register and the queue before the back part
// reset clears all counters, the loss run length to one and Gmin to 16
// the front stage and a two-entry queue keep taking items while the back
// part works or while a result waits for m_tready
module voip_burst_gap_loss_stats #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,    // command
	input  logic [7:0]  s_tdata,    // repeat_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // loss_ratio, discard_ratio, burst_ratio, gap_ratio
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import vbgls_pkg::*;

	localparam int DW = COUNTER_WIDTH + 2;

	logic            gmin_nonzero;
	logic [7:0]      gmin_q;

	// front to queue
	logic            f_valid;
	logic            f_ready;
	op_t             f_op;
	// queue to back
	logic            b_valid;
	logic            b_ready;
	op_t             b_op;
	// divider link
	div_req_t        div_req;
	div_stat_t       div_stat;
	logic [DW-1:0]   div_num;
	logic [DW-1:0]   div_den;
	logic [7:0]      div_quo;
	res_t            res;

	// config is always taken; the user keeps the block idle whenever it is written
	assign cfg_ready = 1'b1;
	assign gmin_nonzero = (gmin_q != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gmin_q <= GMIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gmin_q <= cfg_data;
		end
	end

	// classify incoming events
	vbgls_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.op_valid (f_valid),
		.op_ready (f_ready),
		.op_data  (f_op)
	);

	// decouples intake from the slow back part
	vbgls_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_op     (f_op),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_op    (b_op)
	);

	// counters, loss loop and ratio sequencing with its output register
	vbgls_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.gap_threshold (gmin_q),
		.op_valid      (b_valid),
		.op_ready      (b_ready),
		.op_data       (b_op),
		.div_req       (div_req),
		.div_num       (div_num),
		.div_den       (div_den),
		.div_stat      (div_stat),
		.div_quo       (div_quo),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_res         (res)
	);

	// shared ratio divider
	vbgls_div #(
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	assign m_tdata = {res.gap_ratio, res.burst_ratio, res.discard_ratio, res.loss_ratio};

`ifndef ASSERT_OFF
	// the back part leaves idle right after taking an operation
	a_single_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && b_ready) |=> !(b_valid && b_ready))
		else $error("back part took two operations in a row");

	// a new ratio only starts on an idle divider
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// lost plus discarded never exceeds all packets
	a_rate_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (({1'b0, m_tdata[7:0]} + {1'b0, m_tdata[15:8]}) <= 9'd256))
		else $error("loss and discard ratios add up beyond one");

	// a zero threshold is legal but only reachable by a config write
	a_gmin_write: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(gmin_nonzero) |-> $past(cfg_valid && cfg_ready))
		else $error("gap threshold changed without a config write");
`endif

endmodule

FILE: tb/sv/vbgls_checker.sv
// checker for the burst/gap loss statistics block: tracks the packet counters and checks each result
module vbgls_checker #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [1:0]  s_tuser,    // command
	input  logic [7:0]  s_tdata,    // repeat_count
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,    // loss_ratio, discard_ratio, burst_ratio, gap_ratio
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	import vbgls_pkg::*;

	localparam longint unsigned CNT_MAX = (64'd1 << COUNTER_WIDTH) - 64'd1;

	logic [7:0] gmin;
	longint unsigned rx_total, lost_total, disc_total, rx_since_loss, run_len;
	longint unsigned rx_in_gap, lost_in_gap, rx_in_burst, lost_in_burst;
	res_t rates_due[$];
	int mismatches = 0;
	int waiting = 0;

	assign fail_count = mismatches;
	assign pending    = waiting;

	function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
		return (a > CNT_MAX - b) ? CNT_MAX : a + b;
	endfunction

	// num/den in 1/256 units, optionally rounded up, clamped to 8 bits
	function automatic logic [7:0] scaled_ratio(longint unsigned num, longint unsigned den,
			bit round_up);
		longint unsigned q;
		if (den == 0)
			return 8'd0;
		q = num * 64'd256;
		if (round_up)
			q += den - 64'd1;
		q /= den;
		return (q > 64'd255) ? 8'd255 : q[7:0];
	endfunction

	task automatic clear_stats();
		gmin          = GMIN_RESET;
		rx_total      = 0;
		lost_total    = 0;
		disc_total    = 0;
		rx_since_loss = 0;
		run_len       = 1;
		rx_in_gap     = 0;
		lost_in_gap   = 0;
		rx_in_burst   = 0;
		lost_in_burst = 0;
	endtask

	// gmin classification of a single lost or discarded packet
	task automatic classify_loss();
		if (rx_since_loss >= gmin || rx_total <= gmin) begin
			if (run_len == 1)
				lost_in_gap = sat_add(lost_in_gap, 1);
			else
				lost_in_burst = sat_add(lost_in_burst, 1);
			run_len   = 1;
			rx_in_gap = sat_add(rx_in_gap, rx_since_loss);
		end else begin
			run_len       = sat_add(run_len, 1);
			rx_in_burst   = sat_add(rx_in_burst, rx_since_loss);
			lost_in_burst = sat_add(lost_in_burst, 1);
		end
		rx_since_loss = 0;
	endtask

	task automatic apply_packet_event(input logic [1:0] cmd, input logic [7:0] reps,
			output res_t rates);
		longint unsigned all_pkts;
		case (cmd)
			CMD_RECV: begin
				rx_total      = sat_add(rx_total, 1);
				rx_since_loss = sat_add(rx_since_loss, 1);
			end
			CMD_LOST: begin
				for (int i = 0; i < reps; i++) begin
					lost_total = sat_add(lost_total, 1);
					classify_loss();
				end
			end
			CMD_DISC: begin
				disc_total = sat_add(disc_total, 1);
				classify_loss();
			end
			default: ;    // unknown command leaves everything alone
		endcase
		all_pkts            = rx_total + lost_total + disc_total;
		rates.loss_ratio    = scaled_ratio(lost_total, all_pkts, 1'b0);
		rates.discard_ratio = scaled_ratio(disc_total, all_pkts, 1'b0);
		rates.burst_ratio   = scaled_ratio(lost_in_burst, rx_in_burst + lost_in_burst, 1'b1);
		rates.gap_ratio     = scaled_ratio(lost_in_gap,
			rx_in_gap + lost_in_gap + rx_since_loss, 1'b1);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch
		res_t want;
		res_t got;
		if (!arst_n) begin
			clear_stats();
			rates_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				gmin = cfg_data;
			if (s_tvalid && s_tready) begin
				apply_packet_event(s_tuser, s_tdata, want);
				rates_due = {rates_due, want};
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (rates_due.size() == 0) begin
					report_mismatch("unexpected result word", got, 0);
				end else begin
					want = rates_due.pop_front();
					if (got.loss_ratio != want.loss_ratio)
						report_mismatch("loss ratio", got.loss_ratio, want.loss_ratio);
					if (got.discard_ratio != want.discard_ratio)
						report_mismatch("discard ratio", got.discard_ratio,
							want.discard_ratio);
					if (got.burst_ratio != want.burst_ratio)
						report_mismatch("burst ratio", got.burst_ratio, want.burst_ratio);
					if (got.gap_ratio != want.gap_ratio)
						report_mismatch("gap ratio", got.gap_ratio, want.gap_ratio);
				end
			end
		end
		waiting = rates_due.size();
	end

endmodule

FILE: tb/sv/tb_voip_burst_gap_loss_stats.sv
// stimulus and verdict for the burst/gap loss statistics block
module tb_voip_burst_gap_loss_stats;
	import vbgls_pkg::*;

	localparam int COUNTER_WIDTH = 32;
	// command 3 has no meaning to the block: it must change nothing
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	// cycles with no handshake on any channel before we give up; well above the
	// slowest item and the long receiver hold-off
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	// drain time after the last result, a little above one worst-case item
	localparam int TAIL_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;    // command
	logic [7:0]  s_tdata;    // repeat_count
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;    // loss_ratio, discard_ratio, burst_ratio, gap_ratio
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	int checker_fails;
	int pending;

	// idling percentages, changed per phase by the stimulus
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// threshold currently programmed, used to shape the receive runs
	int gmin_now = int'(GMIN_RESET);

	// long receiver hold-off: stimulus bumps the request, receiver counts it out
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	voip_burst_gap_loss_stats #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	vbgls_checker #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(checker_fails),
		.pending   (pending)
	);

	// result side: random back-pressure, or a solid hold-off when requested
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one packet event, entered and left at a falling edge; valid stays
	// high into the next call so back-to-back items need no gap
	task automatic send_event(input logic [1:0] cmd, input logic [7:0] reps);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= reps;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// sender goes quiet until every predicted result has been taken
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// only called with the block drained
	task automatic write_gmin(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		gmin_now = int'(value);
	endtask

	function automatic logic [7:0] loss_burst_len();
		int pick;
		pick = $urandom_range(99);
		if (pick < 85)
			return 8'($urandom_range(4, 1));
		else if (pick < 97)
			return 8'($urandom_range(32, 5));
		return 8'($urandom_range(255, 33));
	endfunction

	// mostly well-formed traffic: a run of receives sized around gmin (at most 40) so that
	// both sides of the threshold show up, then a loss or discard; the rest
	// is noise (unknown commands, empty losses, fully random events)
	task automatic random_traffic(input int n_events);
		int done_events;
		int run_len;
		int run_cap;
		done_events = 0;
		while (done_events < n_events) begin
			if ($urandom_range(99) < 80) begin
				run_cap = (gmin_now > 19) ? 40 : 2 * gmin_now + 1;
				run_len = $urandom_range(run_cap, 0);
				repeat (run_len)
					send_event(CMD_RECV, 8'($urandom_range(255)));
				if ($urandom_range(3) == 0)
					send_event(CMD_DISC, 8'($urandom_range(255)));
				else
					send_event(CMD_LOST, loss_burst_len());
				done_events += run_len + 1;
			end else begin
				case ($urandom_range(3))
					0: send_event(CMD_UNKNOWN, 8'($urandom_range(255)));
					1: send_event(CMD_LOST, 8'd0);
					default: begin
						send_event(2'($urandom_range(3)), 8'($urandom_range(255)));
						done_events++;
					end
				endcase
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = '0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;

		// single reset at the start, released on a falling edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// slow sender, very lazy receiver
		send_idle_pct = 15;
		recv_idle_pct = 75;

		// gmin 1: tiny threshold so bursts appear within a few items
		write_gmin(8'd1);
		send_event(CMD_UNKNOWN, 8'd0);    // unknown command on empty counters
		send_event(CMD_RECV, 8'hff);
		send_event(CMD_LOST, 8'd0);       // zero repeat count loses nothing
		send_event(CMD_RECV, 8'h00);
		send_event(CMD_LOST, 8'd1);       // gap loss
		send_event(CMD_LOST, 8'd1);       // straight after: burst loss
		send_event(CMD_DISC, 8'h55);
		send_event(CMD_RECV, 8'haa);
		send_event(CMD_LOST, 8'd3);       // gap then burst within one event
		send_event(CMD_UNKNOWN, 8'hff);
		send_event(CMD_RECV, 8'd7);
		send_event(CMD_RECV, 8'd8);
		send_event(CMD_DISC, 8'd0);
		send_event(CMD_LOST, 8'd255);     // longest loss run in one event
		send_event(CMD_RECV, 8'd1);
		send_event(CMD_DISC, 8'hf0);
		drain_results();

		// gmin 0: every loss is a gap loss
		write_gmin(8'd0);
		send_event(CMD_RECV, 8'd0);
		send_event(CMD_LOST, 8'd2);
		send_event(CMD_DISC, 8'd0);
		send_event(CMD_LOST, 8'd1);
		drain_results();

		// gmin at its top value
		write_gmin(8'd255);
		send_event(CMD_RECV, 8'd0);
		send_event(CMD_LOST, 8'd1);
		send_event(CMD_LOST, 8'd4);
		drain_results();

		// random phases: two per idling mode, a new threshold each
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_gmin(GMIN_RESET);
				1: write_gmin(8'($urandom_range(8, 2)));
				2: write_gmin(8'd1);
				3: write_gmin(8'($urandom_range(255, 1)));
				4: write_gmin(8'($urandom_range(12, 3)));
				default: write_gmin(8'($urandom_range(6, 1)));
			endcase
			if (phase == 2) begin
				send_idle_pct = 75;
				recv_idle_pct = 15;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// receiver stops dead while the sender keeps pushing, so the
			// internal queue fills and the input stalls
			if (phase == 5)
				hold_requests++;
			random_traffic(40);
			// pause mid-phase until everything has come back
			if (phase == 4)
				drain_results();
			random_traffic(40);
			drain_results();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (checker_fails == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
